/* hdl/mrd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mrd_pkg
// Shared constants, codes and types of the memory region decoder.
// ----------------------------------------------------------------------------
package mrd_pkg;

	localparam int NUM_REGIONS  = 4;
	localparam int REGION_BYTES = 16384;
	localparam int TABLE_SLOTS  = 4;

	localparam int STORE_DEPTH = NUM_REGIONS * REGION_BYTES;
	localparam int STORE_AW    = $clog2(STORE_DEPTH);

	localparam int ADDR_W  = 16;
	localparam int LEN_W   = 17;
	localparam int BYTE_W  = 8;
	localparam int COUNT_W = 3;
	localparam int SLOT_W  = 2;
	localparam int CFG_W   = 35;
	localparam int IDX_W   = 3;

	localparam logic [BYTE_W-1:0] MISS_BYTE = 8'hff;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_LOAD  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [IDX_W-1:0] {
		CFG_COUNT   = 3'd0,
		CFG_REGION0 = 3'd1,
		CFG_REGION1 = 3'd2,
		CFG_REGION2 = 3'd3,
		CFG_REGION3 = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic              active;
		logic              writable;
		logic [LEN_W-1:0]  length;
		logic [ADDR_W-1:0] start;
	} region_t;

	typedef struct packed {
		logic                rd_en;
		logic                wr_en;
		logic                hit;
		logic [STORE_AW-1:0] idx;
	} acc_t;

	function automatic logic [STORE_AW-1:0] store_index(input logic [SLOT_W-1:0] slot,
		input logic [ADDR_W-1:0] off);
		int sum;
		sum = int'(slot) * REGION_BYTES + int'(off);
		return sum[STORE_AW-1:0];
	endfunction

endpackage
`default_nettype wire

/* hdl/mrd_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mrd_ram
// Single-port byte store with registered read data.
// ----------------------------------------------------------------------------
module mrd_ram #(
	parameter int DEPTH = 256,
	parameter int AW    = 8,
	parameter int DW    = 8
) (
	input  wire  logic          clk,
	input  wire  logic          we,
	input  wire  logic          re,
	input  wire  logic [AW-1:0] addr,
	input  wire  logic [DW-1:0] wdata,
	output logic       [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule
`default_nettype wire

/* hdl/mrd_decode.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mrd_decode
// Region table registers and parallel region comparators.
// ----------------------------------------------------------------------------
module mrd_decode (
	input  wire  logic                          clk,
	input  wire  logic                          arst_n,
	input  wire  logic                          cfg_we,
	input  wire  logic [mrd_pkg::IDX_W-1:0]     cfg_index,
	input  wire  logic [mrd_pkg::CFG_W-1:0]     cfg_data,
	input  wire  mrd_pkg::op_t                  op,
	input  wire  logic [mrd_pkg::ADDR_W-1:0]    address,
	input  wire  logic [mrd_pkg::SLOT_W-1:0]    load_region,
	output mrd_pkg::acc_t                       acc
);
	import mrd_pkg::*;

	logic [COUNT_W-1:0] count_q;
	region_t            region_q [TABLE_SLOTS];

	logic [COUNT_W-1:0] live;
	logic [ADDR_W-1:0]  off      [TABLE_SLOTS];
	logic [ADDR_W+1:0]  end_addr [TABLE_SLOTS];
	logic               in_range [TABLE_SLOTS];
	logic               rd_any;
	logic               wr_any;
	logic [SLOT_W-1:0]  rd_sel;
	logic [SLOT_W-1:0]  wr_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			region_q[0] <= '0;
			region_q[1] <= '0;
			region_q[2] <= '0;
			region_q[3] <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_COUNT:   count_q     <= cfg_data[COUNT_W-1:0];
				CFG_REGION0: region_q[0] <= region_t'(cfg_data);
				CFG_REGION1: region_q[1] <= region_t'(cfg_data);
				CFG_REGION2: region_q[2] <= region_t'(cfg_data);
				CFG_REGION3: region_q[3] <= region_t'(cfg_data);
				default: ;
			endcase
		end
	end

	always_comb begin
		live = (count_q > COUNT_W'(NUM_REGIONS)) ? COUNT_W'(NUM_REGIONS) : count_q;
		for (int r = 0; r < TABLE_SLOTS; r++) begin
			off[r]      = address - region_q[r].start;
			end_addr[r] = {2'b00, region_q[r].start} + {1'b0, region_q[r].length};
			in_range[r] = (address >= region_q[r].start)
				&& ({2'b00, address} < end_addr[r])
				&& ({1'b0, off[r]} < LEN_W'(REGION_BYTES))
				&& (COUNT_W'(r) < live);
		end
		rd_any = 1'b0;
		wr_any = 1'b0;
		rd_sel = '0;
		wr_sel = '0;
		for (int r = TABLE_SLOTS - 1; r >= 0; r--) begin
			if (in_range[r] && region_q[r].active) begin
				rd_any = 1'b1;
				rd_sel = SLOT_W'(r);
			end
			if (in_range[r] && region_q[r].active && region_q[r].writable) begin
				wr_any = 1'b1;
				wr_sel = SLOT_W'(r);
			end
		end

		acc = '0;
		case (op)
			OP_READ: begin
				acc.rd_en = rd_any;
				acc.hit   = rd_any;
				acc.idx   = store_index(rd_sel, off[rd_sel]);
			end
			OP_WRITE: begin
				acc.wr_en = wr_any;
				acc.hit   = wr_any;
				acc.idx   = store_index(wr_sel, off[wr_sel]);
			end
			OP_LOAD: begin
				if (({1'b0, load_region} < COUNT_W'(NUM_REGIONS))
					&& ({1'b0, address} < LEN_W'(REGION_BYTES))) begin
					acc.wr_en = 1'b1;
					acc.hit   = 1'b1;
				end
				acc.idx = store_index(load_region, address);
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

/* hdl/memory_region_decoder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// memory_region_decoder
// Byte memory map over a table of regions, each backed by its own slice of one shared store.
//
//   channel  dir  fields (lowest bit up)
//   s_*      in   tdata: address[15:0] data[23:16]; tuser: operation[1:0] load_region[3:2]
//   m_*      out  tdata: read_data[7:0]; tuser: hit
//   cfg_*    in   index 0 region_count, 1..4 region_0..region_3
//
// One request per cycle while s_tready is high; results pass the s1 and output registers.
// The single-port store takes at most one read or write per request at accept time.
// After reset a clearing pass zeroes all 65536 bytes (STORE_DEPTH) of the store
// with s_tready low; configuration writes are taken during it.
// A stalled output holds two requests in flight before s_tready drops.
// ----------------------------------------------------------------------------
module memory_region_decoder (
	input  wire  logic                          clk,
	input  wire  logic                          arst_n,
	input  wire  logic                          s_tvalid,
	output logic                                s_tready,
	input  wire  logic [23:0]                   s_tdata,  // address, data
	input  wire  logic [3:0]                    s_tuser,  // operation, load_region
	output logic                                m_tvalid,
	input  wire  logic                          m_tready,
	output logic       [7:0]                    m_tdata,  // read_data
	output logic                                m_tuser,  // hit
	input  wire  logic                          cfg_we,
	input  wire  logic [mrd_pkg::IDX_W-1:0]     cfg_index,
	input  wire  logic [mrd_pkg::CFG_W-1:0]     cfg_data
);
	import mrd_pkg::*;

	op_t                 op;
	logic [ADDR_W-1:0]   address;
	logic [BYTE_W-1:0]   data;
	logic [SLOT_W-1:0]   load_region;
	acc_t                acc;

	logic                clr_busy_q;
	logic [STORE_AW-1:0] clr_q;

	logic                accept;
	logic                adv1;
	logic                ram_we;
	logic                ram_re;
	logic [STORE_AW-1:0] ram_addr;
	logic [BYTE_W-1:0]   ram_wdata;
	logic [BYTE_W-1:0]   ram_rdata;

	logic                v1_s1;
	logic                rd_s1;
	logic                hit_s1;
	logic [BYTE_W-1:0]   byte_s1;

	logic                out_v_q;
	logic [BYTE_W-1:0]   out_data_q;
	logic                out_hit_q;

	assign op          = op_t'(s_tuser[1:0]);
	assign load_region = s_tuser[3:2];
	assign address     = s_tdata[15:0];
	assign data        = s_tdata[23:16];

	mrd_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.op          (op),
		.address     (address),
		.load_region (load_region),
		.acc         (acc)
	);

	assign adv1     = !out_v_q || m_tready;
	assign s_tready = !clr_busy_q && (!v1_s1 || adv1);
	assign accept   = s_tvalid && s_tready;

	assign ram_we    = clr_busy_q || (accept && acc.wr_en);
	assign ram_re    = accept && acc.rd_en;
	assign ram_addr  = clr_busy_q ? clr_q : acc.idx;
	assign ram_wdata = clr_busy_q ? '0 : data;

	mrd_ram #(
		.DEPTH (STORE_DEPTH),
		.AW    (STORE_AW),
		.DW    (BYTE_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// clear pass, then advance requests
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_q      <= '0;
			v1_s1      <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == STORE_AW'(STORE_DEPTH - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (accept) begin
				v1_s1 <= 1'b1;
			end else if (adv1) begin
				v1_s1 <= 1'b0;
			end
			if (v1_s1 && adv1) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1   <= acc.rd_en;
			hit_s1  <= acc.hit;
			byte_s1 <= (op == OP_READ || op == OP_NONE) ? MISS_BYTE : data;
		end
		if (v1_s1 && adv1) begin
			out_data_q <= rd_s1 ? ram_rdata : byte_s1;
			out_hit_q  <= hit_s1;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_hit_q;

endmodule
`default_nettype wire

/* hdl/mrd_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mrd_checker
// Port-level checks of the memory region decoder, bound to the top level.
// ----------------------------------------------------------------------------
module mrd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tvalid,
	input wire logic       s_tready,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic       m_tuser
);

	logic [1:0] pend_q;
	logic       s_acc;
	logic       m_acc;

	assign s_acc = s_tvalid && s_tready;
	assign m_acc = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, s_acc} - {1'b0, m_acc};
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != 2'd0)
		else $error("result without request");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == 2'd2 && !m_acc |-> !s_tready)
		else $error("more than two requests in flight");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !s_tready)
		else $error("request taken before store clear");

endmodule

bind memory_region_decoder mrd_checker u_mrd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire

/* tb/memory_region_decoder_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// memory_region_decoder_checker
// Watches the register port and both stream channels of the region decoder,
// keeps its own image of the region map and the byte stores, predicts the
// result of every accepted request and compares each returned result with
// the oldest prediction.
// ----------------------------------------------------------------------------
module memory_region_decoder_checker
	import mrd_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	input  wire logic                s_tready,
	input  wire logic [23:0]         s_tdata,   // address[15:0], data[23:16]
	input  wire logic [3:0]          s_tuser,   // operation[1:0], load_region[3:2]
	input  wire logic                m_tvalid,
	input  wire logic                m_tready,
	input  wire logic [7:0]          m_tdata,   // read_data[7:0]
	input  wire logic                m_tuser,   // hit
	input  wire logic                cfg_we,
	input  wire logic [IDX_W-1:0]    cfg_index,
	input  wire logic [CFG_W-1:0]    cfg_data,
	input  wire logic                run_done,
	output int                       pending,
	output int                       errors
);

	typedef struct packed {
		logic [BYTE_W-1:0] read_data;
		logic              hit;
	} access_result_t;

	logic [COUNT_W-1:0] region_count;
	region_t            region_map [TABLE_SLOTS];
	logic [BYTE_W-1:0]  store_image [STORE_DEPTH];
	access_result_t     expected_q [$];

	int fail_count = 0;
	int n_reads, n_writes, n_loads, n_unused, n_cfg, n_hits, n_misses, n_compared;
	bit tail_done;

	assign errors = fail_count;

	task automatic report_mismatch(input string what);
		$display("MISMATCH @%0t: %s", $time, what);
		fail_count++;
	endtask

	function automatic int region_offset(input int slot, input logic [ADDR_W-1:0] addr);
		int unsigned first;
		int unsigned limit;
		first = region_map[slot].start;
		limit = first + region_map[slot].length;
		if (addr < first || addr >= limit || addr - first >= REGION_BYTES)
			return -1;
		return addr - first;
	endfunction

	task automatic decode_access(input op_t op, input logic [ADDR_W-1:0] addr,
		input logic [BYTE_W-1:0] data, input logic [SLOT_W-1:0] sel,
		output access_result_t res);
		int live;
		int off;
		live = (region_count > NUM_REGIONS) ? NUM_REGIONS : region_count;
		res.read_data = MISS_BYTE;
		res.hit = 1'b0;
		case (op)
		OP_READ: begin
			for (int r = 0; r < live && !res.hit; r++) begin
				if (region_map[r].active) begin
					off = region_offset(r, addr);
					if (off >= 0) begin
						res.read_data = store_image[r * REGION_BYTES + off];
						res.hit = 1'b1;
					end
				end
			end
		end
		OP_WRITE: begin
			res.read_data = data;
			for (int r = 0; r < live && !res.hit; r++) begin
				if (region_map[r].active && region_map[r].writable) begin
					off = region_offset(r, addr);
					if (off >= 0) begin
						store_image[r * REGION_BYTES + off] = data;
						res.hit = 1'b1;
					end
				end
			end
		end
		OP_LOAD: begin
			res.read_data = data;
			if (sel < NUM_REGIONS && addr < REGION_BYTES) begin
				store_image[sel * REGION_BYTES + addr] = data;
				res.hit = 1'b1;
			end
		end
		default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		access_result_t want;
		access_result_t got;
		op_t            op;
		if (!arst_n) begin
			region_count = '0;
			for (int r = 0; r < TABLE_SLOTS; r++)
				region_map[r] = '0;
			for (int i = 0; i < STORE_DEPTH; i++)
				store_image[i] = '0;
			expected_q.delete();
			{n_reads, n_writes, n_loads, n_unused} = '0;
			{n_cfg, n_hits, n_misses, n_compared} = '0;
			tail_done = 1'b0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				n_cfg++;
				case (cfg_index)
				CFG_COUNT: region_count = cfg_data[COUNT_W-1:0];
				CFG_REGION0, CFG_REGION1, CFG_REGION2, CFG_REGION3:
					region_map[cfg_index - CFG_REGION0] = region_t'(cfg_data);
				default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				op = op_t'(s_tuser[1:0]);
				decode_access(op, s_tdata[15:0], s_tdata[23:16], s_tuser[3:2], want);
				expected_q.push_back(want);
				case (op)
				OP_READ:  n_reads++;
				OP_WRITE: n_writes++;
				OP_LOAD:  n_loads++;
				default:  n_unused++;
				endcase
				if (want.hit)
					n_hits++;
				else
					n_misses++;
			end
			if (m_tvalid && m_tready) begin
				got.read_data = m_tdata;
				got.hit = m_tuser;
				if (expected_q.size() == 0) begin
					report_mismatch($sformatf("result %02h/%0b with no request waiting",
						got.read_data, got.hit));
				end else begin
					want = expected_q.pop_front();
					n_compared++;
					if (got.read_data !== want.read_data)
						report_mismatch($sformatf("read_data %02h, predicted %02h",
							got.read_data, want.read_data));
					if (got.hit !== want.hit)
						report_mismatch($sformatf("hit %0b, predicted %0b",
							got.hit, want.hit));
				end
			end
			if (run_done && !tail_done) begin
				tail_done = 1'b1;
				while (expected_q.size() > 0) begin
					want = expected_q.pop_front();
					report_mismatch($sformatf("result %02h/%0b never returned",
						want.read_data, want.hit));
				end
				$display("coverage: %0d reads, %0d writes, %0d loads, %0d unused ops, %0d register writes",
					n_reads, n_writes, n_loads, n_unused, n_cfg);
				$display("coverage: %0d hits, %0d misses, %0d results compared",
					n_hits, n_misses, n_compared);
			end
			pending <= expected_q.size();
		end
	end

endmodule

/* tb/memory_region_decoder_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// memory_region_decoder_tb
// Programs the region map through several settings, from an empty table to
// one with every field at its maximum, and sends directed and random memory
// requests aimed at region edges, with random gaps on both stream sides and
// one long output stall. Results are checked by the companion checker.
// ----------------------------------------------------------------------------
module memory_region_decoder_tb;
	import mrd_pkg::*;

	localparam int RESET_CYCLES    = 7;
	localparam int GAP_MAX         = 7;
	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 48;
	localparam int HOLD_PHASE      = 3;
	localparam int RX_HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES    = 8;
	localparam int AIM_SPAN        = 'h5000;
	localparam logic [IDX_W-1:0] CFG_SPARE = IDX_W'(CFG_REGION3 + 1);
	localparam cfg_idx_t REGION_IDX [TABLE_SLOTS] =
		'{CFG_REGION0, CFG_REGION1, CFG_REGION2, CFG_REGION3};

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [23:0]        s_tdata;   // address[15:0], data[23:16]
	logic [3:0]         s_tuser;   // operation[1:0], load_region[3:2]
	logic               m_tvalid;
	logic               m_tready;
	logic [7:0]         m_tdata;   // read_data[7:0]
	logic               m_tuser;   // hit
	logic               cfg_we;
	logic [IDX_W-1:0]   cfg_index;
	logic [CFG_W-1:0]   cfg_data;
	logic               run_done;
	int                 pending;
	int                 errors;

	region_t            plan [TABLE_SLOTS];
	logic [COUNT_W-1:0] map_count;
	bit                 tx_quiet;
	bit                 rx_quiet;
	bit                 rx_hold;

	memory_region_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	memory_region_decoder_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.run_done  (run_done),
		.pending   (pending),
		.errors    (errors)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	task automatic load_map();
		cfg_write(CFG_COUNT, CFG_W'(map_count));
		for (int r = 0; r < TABLE_SLOTS; r++)
			cfg_write(REGION_IDX[r], plan[r]);
		cfg_we <= 1'b0;
	endtask

	task automatic send_request(input op_t op, input logic [ADDR_W-1:0] addr,
		input logic [BYTE_W-1:0] data, input logic [SLOT_W-1:0] sel);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, GAP_MAX);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {data, addr};
		s_tuser <= {sel, op};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	function automatic region_t random_region();
		region_t rg;
		rg.start = ($urandom_range(0, 3) == 0) ? ADDR_W'($urandom)
			: {4'($urandom), 12'h000};
		case ($urandom_range(0, 5))
		0:       rg.length = '0;
		1:       rg.length = LEN_W'($urandom);
		2:       rg.length = '1;
		default: rg.length = LEN_W'($urandom_range(1, 'h6000));
		endcase
		rg.writable = ($urandom_range(0, 3) != 0);
		rg.active = ($urandom_range(0, 4) != 0);
		return rg;
	endfunction

	task automatic random_request();
		int                pick;
		int                span;
		region_t           rg;
		logic [ADDR_W-1:0] addr;
		op_t               op;
		pick = $urandom_range(0, 19);
		op = (pick < 9) ? OP_READ : (pick < 15) ? OP_WRITE : (pick < 19) ? OP_LOAD : OP_NONE;
		pick = $urandom_range(0, 9);
		if (op == OP_LOAD) begin
			if (pick < 5)
				addr = ADDR_W'($urandom_range(0, 255));
			else if (pick < 9)
				addr = ADDR_W'($urandom_range(0, REGION_BYTES - 1));
			else
				addr = ADDR_W'($urandom);
		end else if (pick < 7) begin
			rg = plan[$urandom_range(0, TABLE_SLOTS - 1)];
			span = (rg.length > AIM_SPAN) ? AIM_SPAN : rg.length;
			addr = ADDR_W'(rg.start + $urandom_range(0, span));
		end else begin
			addr = ADDR_W'($urandom);
		end
		send_request(op, addr, BYTE_W'($urandom), SLOT_W'($urandom));
	endtask

	initial begin
		m_tready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin : drain_results
			int gap;
			if (rx_hold) begin
				m_tready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				rx_hold = 1'b0;
			end
			gap = rx_quiet ? 0 : $urandom_range(0, GAP_MAX);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		run_done <= 1'b0;
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		rx_hold = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ROM in front of RAM, RAM longer than its store, region reaching the
		// top of the address space, empty region; count above the table size
		plan[0] = '{active: 1'b1, writable: 1'b0, length: 17'h00100, start: 16'h0000};
		plan[1] = '{active: 1'b1, writable: 1'b1, length: 17'h08000, start: 16'h0000};
		plan[2] = '{active: 1'b1, writable: 1'b1, length: 17'h1ffff, start: 16'hff00};
		plan[3] = '{active: 1'b1, writable: 1'b1, length: 17'h00000, start: 16'h4000};
		map_count = '1;
		load_map();

		send_request(OP_LOAD,  16'h0000, 8'ha5, 2'd0);
		send_request(OP_READ,  16'h0000, 8'h00, 2'd0);
		send_request(OP_WRITE, 16'h0000, 8'h3c, 2'd1);
		send_request(OP_READ,  16'h0000, 8'h00, 2'd2);
		send_request(OP_READ,  16'h0100, 8'h00, 2'd3);
		send_request(OP_WRITE, 16'h3fff, 8'hff, 2'd0);
		send_request(OP_READ,  16'h3fff, 8'h00, 2'd0);
		send_request(OP_WRITE, 16'h4000, 8'h11, 2'd0);
		send_request(OP_READ,  16'h4000, 8'h00, 2'd0);
		send_request(OP_WRITE, 16'hffff, 8'h00, 2'd3);
		send_request(OP_READ,  16'hffff, 8'hff, 2'd3);
		send_request(OP_LOAD,  16'h3fff, 8'h5a, 2'd3);
		send_request(OP_LOAD,  16'h4000, 8'h77, 2'd0);
		send_request(OP_LOAD,  16'hffff, 8'h81, 2'd2);
		send_request(OP_NONE,  16'h1234, 8'h77, 2'd1);
		send_request(OP_READ,  16'hff00, 8'h00, 2'd0);
		send_request(OP_LOAD,  16'h0000, 8'hff, 2'd1);
		send_request(OP_READ,  16'h8000, 8'h00, 2'd0);

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			wait_idle();
			for (int r = 0; r < TABLE_SLOTS; r++)
				plan[r] = (ph == 1) ? '1 : random_region();
			if (ph == 0)
				map_count = '0;
			else if (ph == 1)
				map_count = '1;
			else
				map_count = COUNT_W'($urandom_range(1, 7));
			if (ph == 2)
				cfg_write(IDX_W'($urandom_range(CFG_SPARE, (1 << IDX_W) - 1)),
					CFG_W'({$urandom, $urandom}));
			load_map();
			tx_quiet = ($urandom_range(0, 3) == 0);
			rx_quiet = ($urandom_range(0, 3) == 0);
			if (ph == HOLD_PHASE) begin
				tx_quiet = 1'b1;
				rx_hold = 1'b1;
			end
			repeat (ITEMS_PER_PHASE) random_request();
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		run_done <= 1'b1;
		repeat (2) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
